@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// Every property is clocked on the rising edge and disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/bf2x2_pkg.sv @@
// ----------------------------------------------------------------------------
// bf2x2_pkg
// Shared widths, register indexes and types of the 2x2 RGBA box filter.
// ----------------------------------------------------------------------------
package bf2x2_pkg;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = PIX_W / CH_W;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // Request to the line store: one write and one read at the same address.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } bf2x2_lb_req_t;

endpackage

@@ sv/bf2x2_line_buf.sv @@
// ----------------------------------------------------------------------------
// bf2x2_line_buf
// Single-port line store holding the previous row, read before write.
// ----------------------------------------------------------------------------
module bf2x2_line_buf
    import bf2x2_pkg::*;
(
    input  logic                aclk,
    input  bf2x2_lb_req_t       req,
    output logic [PIX_W-1:0]    rd_data
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    // The old contents are returned while the new pixel replaces them.
    always_ff @(posedge aclk) begin
        if (req.en) begin
            rd_data_reg    <= mem[req.addr];
            mem[req.addr]  <= req.wdata;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bf2x2_avg4.sv @@
// ----------------------------------------------------------------------------
// bf2x2_avg4
// Per-channel floor average of four RGBA pixels.
// ----------------------------------------------------------------------------
module bf2x2_avg4
    import bf2x2_pkg::*;
(
    input  logic [PIX_W-1:0] pix_a,
    input  logic [PIX_W-1:0] pix_b,
    input  logic [PIX_W-1:0] pix_c,
    input  logic [PIX_W-1:0] pix_d,
    output logic [PIX_W-1:0] pix_avg
);

    localparam int SUM_W = CH_W + 2;

    always_comb begin
        logic [SUM_W-1:0] sum;
        pix_avg = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            sum = SUM_W'(pix_a[i*CH_W +: CH_W]) + SUM_W'(pix_b[i*CH_W +: CH_W])
                + SUM_W'(pix_c[i*CH_W +: CH_W]) + SUM_W'(pix_d[i*CH_W +: CH_W]);
            pix_avg[i*CH_W +: CH_W] = sum[SUM_W-1:2];
        end
    end

endmodule

@@ sv/box_filter_2x2_rgba.sv @@
// Timing: a pixel's results pass through the item stage registers and then the output register.
// Throughput: one pixel per cycle while the sink accepts; the last pixel of each row from the second row on
//   makes two results and holds off the next input pixel until the first of them is sent.
// Reset: synchronous, active low; clears counters and handshake state and sets the
//   frame size to 640x480. The line store is not cleared; the frame restarts after reset.
// ----------------------------------------------------------------------------
// box_filter_2x2_rgba
// 2x2 box filter over a raster stream of RGBA8888 pixels with one line store.
// ----------------------------------------------------------------------------
module box_filter_2x2_rgba
    import bf2x2_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [31:0] in_pixel

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [31:0] out_pixel
    output logic                 m_axis_tlast,   // row_end
    output logic                 m_axis_tuser,   // [0] frame_end

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    // Frame size, stored clamped and minus one.
    logic [ADDR_W-1:0] width_m1_reg;
    logic [ROW_W-1:0]  height_m1_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [ROW_W-1:0]  row_reg;

    // Item stage.
    logic              pend1_reg;
    logic              pend2_reg;
    logic              last_row_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  left_pix_reg;
    logic [PIX_W-1:0]  left_above_reg;
    logic [PIX_W-1:0]  above;

    // Output register.
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_data_reg;
    logic              m_last_reg;
    logic              m_user_reg;

    logic              accept;
    logic              out_load;
    logic              pend_any;
    logic              send;
    logic              cfg_write;
    logic              cfg_known;
    logic [ADDR_W-1:0] cfg_w_m1;
    logic [ROW_W-1:0]  cfg_h_m1;
    logic              emit1;
    logic              emit2;
    logic [PIX_W-1:0]  avg_a;
    logic [PIX_W-1:0]  avg_b;
    logic [PIX_W-1:0]  avg_c;
    logic [PIX_W-1:0]  avg_d;
    logic [PIX_W-1:0]  avg_out;
    bf2x2_lb_req_t     lb_req;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);

    always_comb begin
        if (cfg_data < DIM_W'(2)) begin
            cfg_w_m1 = ADDR_W'(1);
        end else if (cfg_data > DIM_W'(MAX_WIDTH)) begin
            cfg_w_m1 = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            cfg_w_m1 = ADDR_W'(cfg_data - DIM_W'(1));
        end
        if (cfg_data < DIM_W'(2)) begin
            cfg_h_m1 = ROW_W'(1);
        end else if (cfg_data > DIM_W'(MAX_HEIGHT)) begin
            cfg_h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            cfg_h_m1 = ROW_W'(cfg_data - DIM_W'(1));
        end
    end

    assign pend_any      = pend1_reg || pend2_reg;
    assign out_load      = !m_valid_reg || m_axis_tready;
    assign send          = out_load && pend_any;
    // A new pixel may enter once the item stage will have nothing left to send.
    assign s_axis_tready = !pend_any || (out_load && !(pend1_reg && pend2_reg));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign emit1 = (row_reg != '0) && (col_reg != '0);
    assign emit2 = (row_reg != '0) && (col_reg == width_m1_reg);

    assign lb_req.en    = accept;
    assign lb_req.addr  = col_reg;
    assign lb_req.wdata = s_axis_tdata;

    bf2x2_line_buf u_line_buf (
        .aclk    (aclk),
        .req     (lb_req),
        .rd_data (above)
    );

    // The first result averages the 2x2 block to the left; the row-end result
    // repeats the last column as its own right neighbour.
    always_comb begin
        if (pend1_reg) begin
            avg_a = left_above_reg;
            avg_b = above;
            avg_c = left_pix_reg;
            avg_d = pix_reg;
        end else begin
            avg_a = above;
            avg_b = above;
            avg_c = pix_reg;
            avg_d = pix_reg;
        end
    end

    bf2x2_avg4 u_avg4 (
        .pix_a   (avg_a),
        .pix_b   (avg_b),
        .pix_c   (avg_c),
        .pix_d   (avg_d),
        .pix_avg (avg_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg  <= ADDR_W'(640 - 1);
            height_m1_reg <= ROW_W'(480 - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            pend1_reg     <= 1'b0;
            pend2_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write && cfg_known) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_m1_reg <= cfg_w_m1;
                end else begin
                    height_m1_reg <= cfg_h_m1;
                end
                col_reg <= '0;
                row_reg <= '0;
            end else if (accept) begin
                if (col_reg == width_m1_reg) begin
                    col_reg <= '0;
                    row_reg <= (row_reg == height_m1_reg) ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_reg <= col_reg + ADDR_W'(1);
                end
            end

            if (accept) begin
                pend1_reg <= emit1;
                pend2_reg <= emit2;
            end else if (send) begin
                if (pend1_reg) begin
                    pend1_reg <= 1'b0;
                end else begin
                    pend2_reg <= 1'b0;
                end
            end

            if (out_load) begin
                m_valid_reg <= pend_any;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg        <= s_axis_tdata;
            last_row_reg   <= (row_reg == height_m1_reg);
            left_pix_reg   <= pix_reg;
            left_above_reg <= above;
        end
        if (send) begin
            m_data_reg <= avg_out;
            m_last_reg <= !pend1_reg;
            m_user_reg <= !pend1_reg && last_row_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

@@ sv/bf2x2_checker.sv @@
// ----------------------------------------------------------------------------
// bf2x2_checker
// Port-level checks on the 2x2 box filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bf2x2_checker
    import bf2x2_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [PIX_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tlast,
    input  logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready
);

    // The end of a frame is always also the end of a row.
    `ASSERT_SAME(a_frame_end_is_row_end, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

    // A result refused by the sink stays on the port unchanged.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // A row-end result never follows another row-end result directly.
    `ASSERT_NEXT(a_row_end_spacing, aclk, aresetn, m_axis_tvalid && m_axis_tready && m_axis_tlast, !(m_axis_tvalid && m_axis_tlast))

    // The configuration channel never back-pressures.
    `ASSERT_SAME(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind box_filter_2x2_rgba bf2x2_checker u_bf2x2_checker (.*);
